[src/stalta_pkg.sv]
// shared types and constants of the sta/lta power trigger
// no dependencies; imported by stalta_mul, sta_lta_event_detector and the testbench
`default_nettype none

package stalta_pkg;

  // default build parameters
  localparam int DEF_MAX_WINDOW  = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  // fixed field widths
  localparam int LEN_CFG_W  = 7;   // window length registers
  localparam int THR_W      = 16;  // ratio threshold, unsigned q8.8
  localparam int THR_FRAC_W = 8;   // fraction bits of the threshold
  localparam int ENERGY_W   = 37;  // sums of squares wrap at this width
  localparam int POS_W      = 32;  // sample index

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_LEN = 2'd0,
    REG_LONG_LEN  = 2'd1,
    REG_THRESHOLD = 2'd2
  } cfg_reg_t;

  // register reset values
  localparam logic [LEN_CFG_W-1:0] RST_SHORT_LEN = LEN_CFG_W'(2);
  localparam logic [LEN_CFG_W-1:0] RST_LONG_LEN  = LEN_CFG_W'(5);
  localparam logic [THR_W-1:0]     RST_THRESHOLD = THR_W'(384);  // 1.5

  // what the shared multiplier computes
  typedef enum logic [1:0] {
    MUL_SQUARE,     // sample squared
    MUL_SHORT_LEN,  // short energy times long length
    MUL_LONG_LEN,   // long energy times short length
    MUL_THRESH      // partial product times threshold
  } mul_op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_MUL_LHS,
    ST_MUL_RHS_A,
    ST_MUL_RHS_B,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

[src/stalta_ring.sv]
// sample history ring: one write port, one registered read port
// uses nothing outside this file
`default_nettype none

module stalta_ring #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[src/stalta_mul.sv]
// shared multiplier with operand select: squares, length and threshold products
// depends on stalta_pkg
`default_nettype none

module stalta_mul #(
  parameter int MAX_WINDOW  = stalta_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = stalta_pkg::DEF_SAMPLE_BITS
) (
  input  stalta_pkg::mul_op_t                    op,
  input  logic [SAMPLE_BITS-1:0]                 sample,
  input  logic [stalta_pkg::ENERGY_W-1:0]        energy_short,
  input  logic [stalta_pkg::ENERGY_W-1:0]        energy_long,
  input  logic [stalta_pkg::ENERGY_W+$clog2(MAX_WINDOW+1)-1:0] partial,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]        len_long,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]        len_short,
  input  logic [stalta_pkg::THR_W-1:0]           threshold,
  output logic [stalta_pkg::ENERGY_W+$clog2(MAX_WINDOW+1)
                + ((SAMPLE_BITS > stalta_pkg::THR_W) ? SAMPLE_BITS
                   : stalta_pkg::THR_W)-1:0]     product
);

  import stalta_pkg::*;

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int MA_W  = ENERGY_W + LEN_W;
  localparam int MB_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic [SAMPLE_BITS-1:0] mag;
  logic [MA_W-1:0]        a_op;
  logic [MB_W-1:0]        b_op;

  // magnitude of a two's complement sample, most negative value included
  assign mag = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;

  always_comb begin
    unique case (op)
      MUL_SQUARE: begin
        a_op = MA_W'(mag);
        b_op = MB_W'(mag);
      end
      MUL_SHORT_LEN: begin
        a_op = MA_W'(energy_short);
        b_op = MB_W'(len_long);
      end
      MUL_LONG_LEN: begin
        a_op = MA_W'(energy_long);
        b_op = MB_W'(len_short);
      end
      MUL_THRESH: begin
        a_op = partial;
        b_op = MB_W'(threshold);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign product = a_op * b_op;

endmodule

`default_nettype wire

[src/sta_lta_event_detector.sv]
// sta/lta seismic event trigger, top level: sequencer, registers, output stage
// depends on stalta_pkg, stalta_ring and stalta_mul
//
// usage
//   input channel: one signed sample per beat (in_valid/in_ready)
//   result channel: one beat per sample with event flag, primed flag and
//     the sample index since reset (out_valid/out_ready)
//   config port: cfg_wr_en with cfg_index 0 short length, 1 long length,
//     2 q8.8 ratio threshold; unknown indexes are dropped
// sequencing
//   a sample before the long window is full goes from idle straight to
//   emit; after that the ring is walked over the newest L taps, L the
//   effective long length, each tap a ring read, then square and
//   accumulate through the one shared multiplier, followed by three
//   passes through the same multiplier and a compare
//   in_ready is high only while the sequencer waits for a sample
// stall and reset
//   the result sits in an output register; the next sample is accepted
//   while it waits, and the sequencer holds in its last state until the
//   register is free
//   reset clears the state, pointers, counters and output valid flag;
//   no clearing pass, the ring is only read where it has been written
`default_nettype none

module sta_lta_event_detector #(
  parameter int MAX_WINDOW  = stalta_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = stalta_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [stalta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stalta_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_event_res,
  output logic                                out_primed,
  output logic [stalta_pkg::POS_W-1:0]        out_position
);

  import stalta_pkg::*;

  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int MA_W   = ENERGY_W + LEN_W;
  localparam int MB_W   = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int PROD_W = MA_W + MB_W;
  localparam int LHS_W  = ENERGY_W + LEN_W;
  localparam int RHS_W  = ENERGY_W + LEN_W + THR_W;

  // configuration registers
  logic [LEN_CFG_W-1:0] cfg_short_r;
  logic [LEN_CFG_W-1:0] cfg_long_r;
  logic [THR_W-1:0]     cfg_thr_r;

  // control state
  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [LEN_W-1:0]  seen_r, seen_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;

  // per-sample working registers
  logic [PTR_W-1:0]    slot_r, slot_nxt;
  logic [LEN_W-1:0]    k_r, k_nxt;
  logic [ENERGY_W-1:0] acc_r, acc_nxt;
  logic [ENERGY_W-1:0] short_e_r, short_e_nxt;
  logic [ENERGY_W-1:0] long_e_r, long_e_nxt;
  logic [MA_W-1:0]     tmp_r, tmp_nxt;
  logic [LHS_W-1:0]    lhs_r, lhs_nxt;
  logic [RHS_W-1:0]    rhs_r, rhs_nxt;
  logic                primed_r, primed_nxt;
  logic [POS_W-1:0]    item_pos_r, item_pos_nxt;

  // output register
  logic             out_event_r, out_event_nxt;
  logic             out_primed_r, out_primed_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;

  // effective window lengths
  logic [LEN_W-1:0] llen_eff;
  logic [LEN_W-1:0] sclamp;
  logic [LEN_W-1:0] slen_eff;

  logic [LEN_W-1:0]       seen_inc;
  logic                   in_fire;
  logic                   event_calc;
  logic [SAMPLE_BITS-1:0] rd_data;
  mul_op_t                mul_op;
  logic [PROD_W-1:0]      product;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_short_r <= RST_SHORT_LEN;
      cfg_long_r  <= RST_LONG_LEN;
      cfg_thr_r   <= RST_THRESHOLD;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SHORT_LEN: cfg_short_r <= cfg_wdata[LEN_CFG_W-1:0];
        REG_LONG_LEN:  cfg_long_r  <= cfg_wdata[LEN_CFG_W-1:0];
        REG_THRESHOLD: cfg_thr_r   <= cfg_wdata[THR_W-1:0];
        default: ;  // no such register
      endcase
    end
  end

  // zero counts as one, anything past the ring counts as the ring depth,
  // and the short window never reaches past the long one
  always_comb begin
    if (cfg_long_r == '0) begin
      llen_eff = LEN_W'(1);
    end else if (int'(cfg_long_r) > MAX_WINDOW) begin
      llen_eff = LEN_W'(MAX_WINDOW);
    end else begin
      llen_eff = LEN_W'(cfg_long_r);
    end
    if (cfg_short_r == '0) begin
      sclamp = LEN_W'(1);
    end else if (int'(cfg_short_r) > MAX_WINDOW) begin
      sclamp = LEN_W'(MAX_WINDOW);
    end else begin
      sclamp = LEN_W'(cfg_short_r);
    end
    slen_eff = (sclamp > llen_eff) ? llen_eff : sclamp;
  end

  // ---------------------------------------------------------------------------
  // datapath parts
  // ---------------------------------------------------------------------------
  assign in_fire = in_valid && in_ready;

  stalta_ring #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (wp_r),
    .wr_data (in_sample),
    .rd_addr (slot_r),
    .rd_data (rd_data)
  );

  stalta_mul #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mul (
    .op           (mul_op),
    .sample       (rd_data),
    .energy_short (short_e_r),
    .energy_long  (long_e_r),
    .partial      (tmp_r),
    .len_long     (llen_eff),
    .len_short    (slen_eff),
    .threshold    (cfg_thr_r),
    .product      (product)
  );

  // samples seen, saturating at the ring depth
  assign seen_inc = (seen_r == LEN_W'(MAX_WINDOW)) ? seen_r : seen_r + LEN_W'(1);

  // short*llen*256 > thr*long*slen, never on an all-zero long window
  assign event_calc = primed_r && (long_e_r != '0) &&
                      ({{(THR_W - THR_FRAC_W){1'b0}}, lhs_r, {THR_FRAC_W{1'b0}}} > rhs_r);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    seen_nxt       = seen_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r;
    slot_nxt       = slot_r;
    k_nxt          = k_r;
    acc_nxt        = acc_r;
    short_e_nxt    = short_e_r;
    long_e_nxt     = long_e_r;
    tmp_nxt        = tmp_r;
    lhs_nxt        = lhs_r;
    rhs_nxt        = rhs_r;
    primed_nxt     = primed_r;
    item_pos_nxt   = item_pos_r;
    out_event_nxt  = out_event_r;
    out_primed_nxt = out_primed_r;
    out_pos_nxt    = out_pos_r;
    mul_op         = MUL_SQUARE;
    in_ready       = 1'b0;

    // result taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // newest sample goes into the ring at wp_r, walk starts there
          slot_nxt     = wp_r;
          wp_nxt       = (wp_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_r + PTR_W'(1);
          seen_nxt     = seen_inc;
          item_pos_nxt = pos_r;
          pos_nxt      = pos_r + POS_W'(1);
          k_nxt        = '0;
          acc_nxt      = '0;
          primed_nxt   = (seen_inc >= llen_eff);
          state_nxt    = (seen_inc >= llen_eff) ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        // ring read address is slot_r, data lands in rd_data
        state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        mul_op  = MUL_SQUARE;
        acc_nxt = acc_r + product[ENERGY_W-1:0];
        if (k_r + LEN_W'(1) == slen_eff) begin
          short_e_nxt = acc_r + product[ENERGY_W-1:0];
        end
        if (k_r + LEN_W'(1) == llen_eff) begin
          long_e_nxt = acc_r + product[ENERGY_W-1:0];
          state_nxt  = ST_MUL_LHS;
        end else begin
          k_nxt     = k_r + LEN_W'(1);
          slot_nxt  = (slot_r == '0) ? PTR_W'(MAX_WINDOW - 1) : slot_r - PTR_W'(1);
          state_nxt = ST_READ;
        end
      end
      ST_MUL_LHS: begin
        mul_op    = MUL_SHORT_LEN;
        lhs_nxt   = product[LHS_W-1:0];
        state_nxt = ST_MUL_RHS_A;
      end
      ST_MUL_RHS_A: begin
        mul_op    = MUL_LONG_LEN;
        tmp_nxt   = product[MA_W-1:0];
        state_nxt = ST_MUL_RHS_B;
      end
      ST_MUL_RHS_B: begin
        mul_op    = MUL_THRESH;
        rhs_nxt   = product[RHS_W-1:0];
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_event_nxt  = event_calc;
          out_primed_nxt = primed_r;
          out_pos_nxt    = item_pos_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      seen_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      seen_r      <= seen_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    k_r          <= k_nxt;
    acc_r        <= acc_nxt;
    short_e_r    <= short_e_nxt;
    long_e_r     <= long_e_nxt;
    tmp_r        <= tmp_nxt;
    lhs_r        <= lhs_nxt;
    rhs_r        <= rhs_nxt;
    primed_r     <= primed_nxt;
    item_pos_r   <= item_pos_nxt;
    out_event_r  <= out_event_nxt;
    out_primed_r <= out_primed_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;
  assign out_primed    = out_primed_r;
  assign out_position  = out_pos_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_event_needs_primed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_event_res || out_primed))
    else $error("event flagged before the long window was full");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result loaded outside the emit state");

  a_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (pos_r == $past(pos_r) + POS_W'(1)))
    else $error("sample index did not advance on an accepted beat");

  a_ring_pointer_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (wp_r == (($past(wp_r) == PTR_W'(MAX_WINDOW - 1)) ? '0
                          : $past(wp_r) + PTR_W'(1))))
    else $error("ring write pointer stepped wrong");

endmodule

`default_nettype wire

[tb/tb_sta_lta_event_detector.sv]
// testbench for the sta/lta power trigger: directed and random sample streams
// depends on stalta_pkg and sta_lta_event_detector; self-checking, no files read
`default_nettype none

module tb_sta_lta_event_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import stalta_pkg::*;

  // ring depth and sample width of the default build
  localparam int RING_DEPTH = DEF_MAX_WINDOW;
  localparam int SMP_W      = DEF_SAMPLE_BITS;

  // register index the block does not decode, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  // receiver hold-off length and end-of-run settle, sized from a full-depth ring walk per sample
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 2 * RING_DEPTH + 10;

  typedef struct packed {
    logic             event_res;
    logic             primed;
    logic [POS_W-1:0] position;
  } trigger_result_t;

  // power trigger predictor and queue of pending results
  class trigger_scoreboard;
    logic [SMP_W-1:0]  ring [RING_DEPTH];
    bit [5:0]          wr_slot;
    int unsigned       seen_cnt;
    bit [POS_W-1:0]    next_pos;
    bit [LEN_CFG_W-1:0] short_len_reg;
    bit [LEN_CFG_W-1:0] long_len_reg;
    bit [THR_W-1:0]    thresh_reg;
    trigger_result_t   pending_q [$];
    int                errors;
    int                checked;
    int                events_seen;
    int                samples_in;

    function new();
      wr_slot       = '0;
      seen_cnt      = 0;
      next_pos      = '0;
      short_len_reg = RST_SHORT_LEN;
      long_len_reg  = RST_LONG_LEN;
      thresh_reg    = RST_THRESHOLD;
      errors        = 0;
      checked       = 0;
      events_seen   = 0;
      samples_in    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SHORT_LEN: short_len_reg = data[LEN_CFG_W-1:0];
        REG_LONG_LEN:  long_len_reg  = data[LEN_CFG_W-1:0];
        REG_THRESHOLD: thresh_reg    = data[THR_W-1:0];
        default: ;  // undecoded index, nothing changes
      endcase
    endfunction

    // zero counts as one, anything past the ring depth as the ring depth
    function int unsigned eff_len(bit [LEN_CFG_W-1:0] len);
      if (len == 0) return 1;
      if (len > RING_DEPTH) return RING_DEPTH;
      return len;
    endfunction

    // sum of squares over the newest count entries of the ring
    function longint unsigned window_power(bit [5:0] newest, int unsigned count);
      longint unsigned acc;
      longint          s;
      bit [5:0]        slot;
      acc = 0;
      for (int unsigned k = 0; k < count; k++) begin
        slot = newest - 6'(k);
        s    = longint'($signed(ring[slot]));
        acc += longint'(s * s);
      end
      return acc & ((64'd1 << ENERGY_W) - 1);
    endfunction

    function void note_sample(logic [SMP_W-1:0] smp);
      bit [5:0]        newest;
      int unsigned     llen;
      int unsigned     slen;
      longint unsigned sta_sum;
      longint unsigned lta_sum;
      longint unsigned lhs;
      longint unsigned rhs;
      trigger_result_t r;
      newest = wr_slot;
      llen   = eff_len(long_len_reg);
      slen   = eff_len(short_len_reg);
      if (slen > llen) slen = llen;
      ring[newest] = smp;
      wr_slot      = newest + 6'd1;
      if (seen_cnt < RING_DEPTH) seen_cnt++;
      r.event_res = 1'b0;
      r.primed    = 1'b0;
      r.position  = next_pos;
      if (seen_cnt >= llen) begin
        r.primed = 1'b1;
        sta_sum  = window_power(newest, slen);
        lta_sum  = window_power(newest, llen);
        lhs = sta_sum * longint'(llen) * 64'd256;
        rhs = longint'(thresh_reg) * lta_sum * longint'(slen);
        if (lta_sum != 0 && lhs > rhs) r.event_res = 1'b1;
      end
      next_pos++;
      samples_in++;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic ev, logic pr, logic [POS_W-1:0] pos);
      trigger_result_t r;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing pending: position %0d", pos);
        errors++;
        return;
      end
      r = pending_q.pop_front();
      checked++;
      if (ev === 1'b1) events_seen++;
      if (ev !== r.event_res) begin
        $error("event_res: expected %0d, got %0d (position %0d)", r.event_res, ev, r.position);
        errors++;
      end
      if (pr !== r.primed) begin
        $error("primed: expected %0d, got %0d (position %0d)", r.primed, pr, r.position);
        errors++;
      end
      if (pos !== r.position) begin
        $error("position: expected %0d, got %0d", r.position, pos);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  // clock, reset and every block input known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SMP_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_event_res;
  logic out_primed;
  logic [POS_W-1:0] out_position;

  trigger_scoreboard sb;

  // idling knobs, changed per phase by the stimulus
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // hold-off request handed to the receiver process, counted down there
  int hold_request = 0;
  int hold_left = 0;
  int burst_left = 0;
  int cfg_writes = 0;

  always #2 clk = ~clk;

  sta_lta_event_detector DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_res (out_event_res),
    .out_primed    (out_primed),
    .out_position  (out_position)
  );

  // beat monitor: values seen here are the ones before this edge's updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_sample(in_sample);
      if (out_valid && out_ready) sb.check_result(out_event_res, out_primed, out_position);
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one sample; valid stays up from the previous beat when no gap is drawn
  task automatic send_sample(input logic [SMP_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait until every pending result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // write enable is left high here; configure lowers it after the last write
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] short_v,
                           input logic [CFG_DATA_W-1:0] long_v,
                           input logic [CFG_DATA_W-1:0] thr_v);
    write_cfg(REG_SHORT_LEN, short_v);
    write_cfg(REG_LONG_LEN, long_v);
    write_cfg(REG_THRESHOLD, thr_v);
    cfg_wr_en <= 1'b0;
  endtask

  // seismic-like trace: low-level noise with bursts of strong motion,
  // scattered zero samples and the odd full-scale spike
  function automatic logic [SMP_W-1:0] trace_sample();
    int amp;
    if (burst_left == 0 && $urandom_range(99) < 8) burst_left = $urandom_range(1, 12);
    if ($urandom_range(99) < 3) return SMP_W'($urandom());
    if (burst_left != 0) begin
      burst_left--;
      amp = $urandom_range(10, SMP_W);
    end else if ($urandom_range(99) < 6) begin
      return '0;
    end else begin
      amp = $urandom_range(1, 6);
    end
    if (amp >= SMP_W) return SMP_W'($urandom());
    return SMP_W'(int'($urandom_range(0, (1 << amp) - 1)) - (1 << (amp - 1)));
  endfunction

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: short 2, long 5, threshold 1.5
    // four samples before the long window fills, then two all-zero windows,
    // then full-scale extremes that should fire
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    drain();

    // undecoded index must be dropped; short 127 saturates to long 3,
    // upper data bits above the length field are ignored, threshold just below 1.0
    write_cfg(CFG_IDX_SPARE, 16'hFFFF);
    configure(16'd127, 16'hFF83, 16'd255);
    send_sample(16'sd100);
    send_sample(-16'sd100);
    send_sample(16'sd7);
    drain();

    // ratio exactly equal to the threshold must not fire
    configure(16'd127, 16'd3, 16'd256);
    send_sample(16'sd9);
    send_sample(-16'sd9);
    drain();

    // zero lengths count as one, threshold zero fires on any nonzero sample
    configure(16'd0, 16'd0, 16'd0);
    send_sample(16'sd0);
    send_sample(16'sd5);
    send_sample(-16'sd32768);
    drain();

    // long window grows past what has been seen: priming drops again
    configure(16'd1, 16'd127, 16'hFFFF);
    send_sample(16'sd32767);
    send_sample(16'sd1);

    // random phases, each with its own settings and idling pattern
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: configure(16'd1, 16'd1, 16'($urandom_range(0, 511)));
        1: configure(16'($urandom_range(1, 8)), 16'd64, 16'($urandom_range(256, 1024)));
        2: configure(16'd127, 16'd127, 16'hFFFF);
        3: configure(16'd0, 16'($urandom_range(2, 20)), 16'($urandom_range(256, 2048)));
        4: configure(16'($urandom()), 16'($urandom()), 16'($urandom()));
        5: configure(16'($urandom_range(1, 4)), 16'($urandom_range(8, 40)), 16'd0);
        6: configure(16'($urandom_range(1, 10)), 16'($urandom_range(10, 64)),
                     16'($urandom_range(300, 800)));
        default: configure(16'($urandom_range(2, 6)), 16'($urandom_range(16, 32)),
                           16'($urandom_range(256, 768)));
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int n = 0; n < 60; n++) begin
        // receiver goes quiet while samples keep coming: the output register
        // fills and in_ready has to drop
        if (phase == 2 && n == 8) hold_request = HOLD_OFF_CYCLES;
        // sender pauses mid-stream until everything is back
        if (phase == 5 && n == 30) drain();
        send_sample(trace_sample());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d samples, %0d result beats checked, %0d events flagged",
             sb.samples_in, sb.checked, sb.events_seen);
    $display("%0d register writes over 13 settings, incl. a long receiver hold-off",
             cfg_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[sta_lta_event_detector] OK");
    end else begin
      if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());
      $display("[sta_lta_event_detector] ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("[sta_lta_event_detector] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
